[hdl/krt_pkg.sv]
// krt_pkg: request and status codes, record type and sequencer states
// for keyed_record_table_unit
// no dependencies
package krt_pkg;

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int TAG_W = 8;
	localparam int CNT_W = 8;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_SEARCH = 2'd1,
		REQ_UPDATE = 2'd2,
		REQ_DELETE = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
		logic [TAG_W-1:0] tag;
	} record_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_SHIFT  = 3'b100
	} state_t;

endpackage

[hdl/keyed_record_table_unit.sv]
// keyed_record_table_unit: dense unsorted record table in one synchronous memory
// depends on krt_pkg
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid in_stall req_type key_id         | in
//          | value_bits tag_char                       |
//  result  | out_valid out_stall status out_key        | out
//          | out_value out_tag entry_count             |
//
// insert writes the record at the next free slot, or reports full; search, update
// and delete scan the memory one entry a cycle through a registered read, stopping
// on a match or after the last entry; delete then shifts the later entries down one
// slot through the same read and write ports.
// reset clears the state, fill count and out_valid; memory contents need no clearing.
// requests are stalled while one is in progress or its result waits to be taken.
module keyed_record_table_unit #(
	parameter int DEPTH = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [31:0] key_id,
	input  logic [31:0] value_bits,
	input  logic [7:0]  tag_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] out_key,
	output logic [31:0] out_value,
	output logic [7:0]  out_tag,
	output logic [7:0]  entry_count
);
	import krt_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	state_t        state_q, state_d;
	logic [CW-1:0] fill_q, fill_d;
	logic [AW-1:0] idx_q, idx_d;
	req_t          req_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [TAG_W-1:0] tag_q;

	logic          out_valid_q;
	status_t       stat_q, stat_d;
	record_t       res_q, res_d;
	logic          res_load;

	record_t       mem [DEPTH];
	record_t       mem_rd_s1;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	record_t       wr_data;

	logic          accept;
	logic [CW-1:0] idx_ext;
	logic          at_last, shift_last;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_s1 <= mem[rd_addr];
		end
	end

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != S_IDLE) || out_valid_q;
	assign idx_ext    = CW'(idx_q);
	assign at_last    = (idx_ext + CW'(1)) == fill_q;
	assign shift_last = (idx_ext + CW'(2)) == fill_q;

	always_comb begin
		state_d  = state_q;
		fill_d   = fill_q;
		idx_d    = idx_q;
		rd_en    = 1'b0;
		rd_addr  = idx_q;
		wr_en    = 1'b0;
		wr_addr  = idx_q;
		wr_data  = mem_rd_s1;
		res_load = 1'b0;
		stat_d   = STAT_DONE;
		res_d    = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req_t'(req_type) == REQ_INSERT) begin
						res_load = 1'b1;
						if (fill_q < CW'(DEPTH)) begin
							wr_en   = 1'b1;
							wr_addr = AW'(fill_q);
							wr_data = '{key: key_id, value: value_bits, tag: tag_char};
							fill_d  = fill_q + CW'(1);
						end else begin
							stat_d = STAT_FULL;
						end
					end else if (fill_q == '0) begin
						res_load = 1'b1;
						stat_d   = STAT_NOT_FOUND;
					end else begin
						rd_en   = 1'b1;
						rd_addr = '0;
						idx_d   = '0;
						state_d = S_SEARCH;
					end
				end
			end
			S_SEARCH: begin
				if (mem_rd_s1.key == key_q) begin
					case (req_q)
						REQ_SEARCH: begin
							res_load = 1'b1;
							res_d    = mem_rd_s1;
							state_d  = S_IDLE;
						end
						REQ_UPDATE: begin
							wr_en    = 1'b1;
							wr_data  = '{key: mem_rd_s1.key, value: val_q, tag: tag_q};
							res_load = 1'b1;
							state_d  = S_IDLE;
						end
						default: begin
							if (at_last) begin
								fill_d   = fill_q - CW'(1);
								res_load = 1'b1;
								state_d  = S_IDLE;
							end else begin
								rd_en   = 1'b1;
								rd_addr = AW'(idx_ext + CW'(1));
								state_d = S_SHIFT;
							end
						end
					endcase
				end else if (at_last) begin
					res_load = 1'b1;
					stat_d   = STAT_NOT_FOUND;
					state_d  = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(idx_ext + CW'(1));
					idx_d   = AW'(idx_ext + CW'(1));
				end
			end
			S_SHIFT: begin
				wr_en   = 1'b1;
				wr_data = mem_rd_s1;
				if (shift_last) begin
					fill_d   = fill_q - CW'(1);
					res_load = 1'b1;
					state_d  = S_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = AW'(idx_ext + CW'(2));
					idx_d   = AW'(idx_ext + CW'(1));
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		if (accept) begin
			req_q <= req_t'(req_type);
			key_q <= key_id;
			val_q <= value_bits;
			tag_q <= tag_char;
		end
		if (res_load) begin
			stat_q <= stat_d;
			res_q  <= res_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = stat_q;
	assign out_key     = res_q.key;
	assign out_value   = res_q.value;
	assign out_tag     = res_q.tag;
	assign entry_count = CNT_W'(fill_q);

endmodule
